FILE: hw/rtl/sgrg_pkg.sv
package sgrg_pkg;

  // Cell geometry of the unscaled character.
  localparam int unsigned CellW      = 6;
  localparam int unsigned CellH      = 8;
  localparam int unsigned GlyphCols  = 5;
  localparam int unsigned GlyphRows  = 7;
  localparam int unsigned RowLimit   = 64;
  localparam int unsigned GlyphCount = 43;

  localparam logic [5:0] BlankGlyph  = 6'd42;

  // Status codes carried with each item.
  localparam logic StatusOk       = 1'b0;
  localparam logic StatusTooLarge = 1'b1;

  typedef logic [GlyphCols-1:0] row_bits_t;

  // Column-major 5x7 font: bit r of a column lights glyph row r.
  localparam logic [7:0] FontRom [GlyphCount][GlyphCols] = '{
    '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
    '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
    '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
    '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
    '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
    '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
    '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
    '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
    '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
    '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
    '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
    '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
    '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
    '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43},
    '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00}, '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00},
    '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08}, '{8'h20, 8'h10, 8'h08, 8'h04, 8'h02},
    '{8'h23, 8'h13, 8'h08, 8'h64, 8'h62}, '{8'h08, 8'h08, 8'h3E, 8'h08, 8'h08},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // Map a character byte to its font slot, folding lower case to upper case.
  function automatic logic [5:0] glyph_slot(input logic [7:0] code);
    logic [7:0] folded;
    logic [5:0] slot;
    folded = code;
    if (code inside {[8'h61:8'h7A]}) begin
      folded = code - 8'h20;
    end
    case (folded) inside
      [8'h30:8'h39]: slot = 6'(folded - 8'h30);
      [8'h41:8'h5A]: slot = 6'(folded - 8'h41 + 8'd10);
      8'h2E:         slot = 6'd36;
      8'h3A:         slot = 6'd37;
      8'h2D:         slot = 6'd38;
      8'h2F:         slot = 6'd39;
      8'h25:         slot = 6'd40;
      8'h2B:         slot = 6'd41;
      default:       slot = BlankGlyph;
    endcase
    return slot;
  endfunction

endpackage

FILE: hw/rtl/scaled_glyph_row_generator.sv
// Pixel row generator for a scaled 5x7 character cell. Pulse start_i while
// busy_o is low to hand in one item; the row's pixels then appear left to
// right, one per cycle, each for exactly one cycle with strobe_o high, and
// the receiver must take them as they come. After an item is taken, one
// shared subtract/compare unit first finds the glyph row as row_index /
// scale by repeated subtraction, then the same unit steps the column counter
// while 6 * scale pixels are emitted, one per cycle, and the last pixel is on
// the ports in the same cycle that busy_o falls. A scale of 0 or a row
// outside the cell gives no pixel and leaves busy_o low; a cell larger than
// MAX_CELL_PIXELS or wider than 64 pixels holds busy_o high for one cycle and
// gives a single too_large result in the next.
module scaled_glyph_row_generator #(
  parameter int unsigned MAX_CELL_PIXELS = 5120
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [7:0]  char_code_i,
  input  logic [3:0]  scale_i,
  input  logic [6:0]  row_index_i,
  input  logic [15:0] fg_color_i,
  input  logic [15:0] bg_color_i,
  output logic        strobe_o,
  output logic [15:0] pixel_color_o,
  output logic        last_pixel_o,
  output logic        status_o
);
  import sgrg_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StEmit,
    StErr
  } state_e;

  state_e     state_q;
  logic [7:0] code_q;
  logic [3:0] scale_q;
  logic [6:0] rem_q;
  logic [2:0] grow_q;
  logic [3:0] sub_q;
  logic [2:0] gcol_q;
  logic [5:0] x_q;
  logic [5:0] width_m1_q;
  logic [15:0] fg_q;
  logic [15:0] bg_q;
  row_bits_t  row_bits_q;
  logic        strobe_q;
  logic [15:0] pixel_q;
  logic        last_q;
  logic        status_q;

  logic       accept;
  logic [7:0] sq;
  logic [13:0] cell_pix;
  logic [6:0] width_in;
  logic       too_large;
  logic       row_out;
  logic [6:0] unit_a;
  logic [7:0] unit_diff;
  logic       lit;
  row_bits_t  rom_bits;

  assign accept = start_i && !busy_o;

  // Size checks on the incoming scale.
  assign sq        = 8'(scale_i) * 8'(scale_i);
  assign cell_pix  = 14'(CellW * CellH) * 14'(sq);
  assign width_in  = 7'(CellW) * 7'(scale_i);
  assign too_large = (32'(cell_pix) > 32'(MAX_CELL_PIXELS)) ||
                     (32'(width_in) > 32'(RowLimit));
  assign row_out   = row_index_i >= {scale_i, 3'b000};

  // Shared subtract unit: the remainder while dividing, the subcolumn count
  // while emitting.
  assign unit_a    = (state_q == StDiv) ? rem_q : 7'(sub_q) + 7'd1;
  assign unit_diff = {1'b0, unit_a} - {4'b0000, scale_q};

  sgrg_glyph_rom u_glyph_rom (
    .code_i      (code_q),
    .glyph_row_i (grow_q),
    .row_bits_o  (rom_bits)
  );

  assign lit = (32'(gcol_q) < GlyphCols) && row_bits_q[gcol_q];

  // Sequencer and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      code_q     <= '0;
      scale_q    <= '0;
      rem_q      <= '0;
      grow_q     <= '0;
      sub_q      <= '0;
      gcol_q     <= '0;
      x_q        <= '0;
      width_m1_q <= '0;
      fg_q       <= '0;
      bg_q       <= '0;
      row_bits_q <= '0;
      strobe_q   <= 1'b0;
      pixel_q    <= '0;
      last_q     <= 1'b0;
      status_q   <= StatusOk;
    end else begin
      strobe_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            code_q     <= char_code_i;
            scale_q    <= scale_i;
            rem_q      <= row_index_i;
            grow_q     <= '0;
            fg_q       <= fg_color_i;
            bg_q       <= bg_color_i;
            width_m1_q <= 6'(width_in - 7'd1);
            if (scale_i == 4'd0) begin
              state_q <= StIdle;
            end else if (too_large) begin
              state_q <= StErr;
            end else if (row_out) begin
              state_q <= StIdle;
            end else begin
              state_q <= StDiv;
            end
          end
        end
        StDiv: begin
          // Subtract the scale until the remainder drops below it.
          if (!unit_diff[7]) begin
            rem_q  <= unit_diff[6:0];
            grow_q <= grow_q + 3'd1;
          end else begin
            row_bits_q <= rom_bits;
            sub_q      <= '0;
            gcol_q     <= '0;
            x_q        <= '0;
            state_q    <= StEmit;
          end
        end
        StEmit: begin
          strobe_q <= 1'b1;
          pixel_q  <= lit ? fg_q : bg_q;
          last_q   <= (x_q == width_m1_q);
          status_q <= StatusOk;
          x_q      <= x_q + 6'd1;
          if (unit_diff == 8'd0) begin
            sub_q  <= '0;
            gcol_q <= gcol_q + 3'd1;
          end else begin
            sub_q  <= unit_a[3:0];
          end
          if (x_q == width_m1_q) begin
            state_q <= StIdle;
          end
        end
        StErr: begin
          strobe_q <= 1'b1;
          pixel_q  <= '0;
          last_q   <= 1'b1;
          status_q <= StatusTooLarge;
          state_q  <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy_o        = (state_q != StIdle);
  assign strobe_o      = strobe_q;
  assign pixel_color_o = pixel_q;
  assign last_pixel_o  = last_q;
  assign status_o      = status_q;

endmodule

FILE: hw/rtl/sgrg_glyph_rom.sv
module sgrg_glyph_rom (
  input  logic [7:0]          code_i,
  input  logic [2:0]          glyph_row_i,
  output sgrg_pkg::row_bits_t row_bits_o
);
  import sgrg_pkg::*;

  logic [5:0] slot;

  assign slot = glyph_slot(code_i);

  // Pick one glyph row across the five columns; the spacing row stays dark.
  always_comb begin
    row_bits_o = '0;
    for (int c = 0; c < GlyphCols; c++) begin
      if (int'(glyph_row_i) < GlyphRows) begin
        row_bits_o[c] = FontRom[slot][c][glyph_row_i];
      end
    end
  end

endmodule

FILE: test/tb_scaled_glyph_row_generator.sv
module tb_scaled_glyph_row_generator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxCellPixels = 5120;
  localparam int unsigned CellWidth     = 6;
  localparam int unsigned CellHeight    = 8;
  localparam int unsigned FontCols      = 5;
  localparam int unsigned FontRows      = 7;
  localparam int unsigned RowMaxPixels  = 64;
  localparam int unsigned BlankSlot     = 42;
  localparam int unsigned RandomItems   = 270;
  localparam int unsigned SettleCycles  = 80;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned ShownLimit    = 10;

  typedef struct packed {
    logic [7:0]  code;
    logic [3:0]  scale;
    logic [6:0]  row;
    logic [15:0] fg;
    logic [15:0] bg;
  } row_request_t;

  typedef struct packed {
    logic [15:0] color;
    logic        last;
    logic        status;
  } pixel_t;

  // Column-major glyph bitmaps: bit r of a column lights glyph row r.
  localparam logic [7:0] GlyphColumns [43][5] = '{
    '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
    '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
    '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
    '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
    '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
    '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
    '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
    '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
    '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
    '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
    '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
    '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
    '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
    '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43},
    '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00}, '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00},
    '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08}, '{8'h20, 8'h10, 8'h08, 8'h04, 8'h02},
    '{8'h23, 8'h13, 8'h08, 8'h64, 8'h62}, '{8'h08, 8'h08, 8'h3E, 8'h08, 8'h08},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // Characters with a glyph, plus a space that falls back to the blank cell.
  string glyph_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz.:-/%+ ";

  // Fold lower case to upper case and find the bitmap of a character.
  function automatic int unsigned font_slot(logic [7:0] ch);
    logic [7:0] upper;
    upper = ch;
    if (ch >= "a" && ch <= "z") begin
      upper = ch - 8'h20;
    end
    if (upper >= "0" && upper <= "9") begin
      return upper - "0";
    end
    if (upper >= "A" && upper <= "Z") begin
      return upper - "A" + 10;
    end
    case (upper)
      ".": return 36;
      ":": return 37;
      "-": return 38;
      "/": return 39;
      "%": return 40;
      "+": return 41;
      default: return BlankSlot;
    endcase
  endfunction

  // Expected pixels of every accepted item, checked in order of arrival.
  class glyph_row_scoreboard;
    pixel_t      expected_pixels[$];
    int unsigned fail_count;

    function void report(string msg);
      fail_count++;
      if (fail_count <= ShownLimit) begin
        $display("%s", msg);
      end
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction

    // Work out the pixels an accepted item causes; returns how many.
    function int unsigned note_request(row_request_t req);
      int unsigned width;
      int unsigned glyph_row;
      int unsigned glyph_col;
      int unsigned slot;
      int unsigned x;
      logic        lit;
      pixel_t      px;
      if (req.scale == 0) begin
        return 0;
      end
      width = CellWidth * req.scale;
      if (CellWidth * CellHeight * req.scale * req.scale > MaxCellPixels ||
          width > RowMaxPixels) begin
        px.color  = 16'h0000;
        px.last   = 1'b1;
        px.status = sgrg_pkg::StatusTooLarge;
        expected_pixels.push_back(px);
        return 1;
      end
      if (req.row >= CellHeight * req.scale) begin
        return 0;
      end
      slot      = font_slot(req.code);
      glyph_row = req.row / req.scale;
      for (x = 0; x < width; x++) begin
        glyph_col = x / req.scale;
        lit = 1'b0;
        // The spacing row and column stay background.
        if (glyph_row < FontRows && glyph_col < FontCols) begin
          lit = GlyphColumns[slot][glyph_col][glyph_row];
        end
        px.color  = lit ? req.fg : req.bg;
        px.last   = (x + 1 == width);
        px.status = sgrg_pkg::StatusOk;
        expected_pixels.push_back(px);
      end
      return width;
    endfunction

    function void check_pixel(logic [15:0] color, logic last, logic status);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        report($sformatf("unexpected pixel: color %h last %b status %b",
                         color, last, status));
        return;
      end
      want = expected_pixels.pop_front();
      if (color !== want.color || last !== want.last || status !== want.status) begin
        report($sformatf({"pixel mismatch: expected color %h last %b status %b, ",
                          "got color %h last %b status %b"},
                         want.color, want.last, want.status, color, last, status));
      end
    endfunction
  endclass

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        start_i      = 1'b0;
  logic [7:0]  char_code_i  = '0;
  logic [3:0]  scale_i      = '0;
  logic [6:0]  row_index_i  = '0;
  logic [15:0] fg_color_i   = '0;
  logic [15:0] bg_color_i   = '0;
  logic        busy_o;
  logic        strobe_o;
  logic [15:0] pixel_color_o;
  logic        last_pixel_o;
  logic        status_o;

  logic        busy_at_neg  = 1'b1;
  int unsigned cycle_count  = 0;
  glyph_row_scoreboard pixels_sb = new();

  scaled_glyph_row_generator #(
    .MAX_CELL_PIXELS(MaxCellPixels)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .char_code_i  (char_code_i),
    .scale_i      (scale_i),
    .row_index_i  (row_index_i),
    .fg_color_i   (fg_color_i),
    .bg_color_i   (bg_color_i),
    .strobe_o     (strobe_o),
    .pixel_color_o(pixel_color_o),
    .last_pixel_o (last_pixel_o),
    .status_o     (status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Outputs are sampled mid-cycle, where they are stable.
  always @(negedge clk_i) begin
    busy_at_neg = busy_o;
    if (rst_ni && strobe_o === 1'b1) begin
      pixels_sb.check_pixel(pixel_color_o, last_pixel_o, status_o);
    end
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("tb_scaled_glyph_row_generator NOT OK");
    $finish;
  end

  function automatic row_request_t make_request(logic [7:0] code, logic [3:0] scale,
                                                logic [6:0] row, logic [15:0] fg,
                                                logic [15:0] bg);
    row_request_t req;
    req.code  = code;
    req.scale = scale;
    req.row   = row;
    req.fg    = fg;
    req.bg    = bg;
    return req;
  endfunction

  // Mostly drawable rows; the rest are oversized cells, rows past the cell
  // and zero scales.
  function automatic row_request_t random_request();
    row_request_t req;
    int unsigned  kind;
    kind    = $urandom_range(0, 99);
    req.fg  = 16'($urandom);
    req.bg  = 16'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      req.bg = req.fg;
    end
    if ($urandom_range(0, 3) == 0) begin
      req.code = 8'($urandom);
    end else begin
      req.code = glyph_chars[$urandom_range(0, glyph_chars.len() - 1)];
    end
    if (kind < 75) begin
      req.scale = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(1, 4))
                                                : 4'($urandom_range(5, 10));
      req.row   = 7'($urandom_range(0, CellHeight * req.scale - 1));
    end else if (kind < 83) begin
      req.scale = 4'($urandom_range(11, 15));
      req.row   = 7'($urandom);
    end else if (kind < 92) begin
      req.scale = 4'($urandom_range(1, 10));
      req.row   = 7'($urandom_range(CellHeight * req.scale, 127));
    end else begin
      req.scale = 4'd0;
      req.row   = 7'($urandom);
    end
    return req;
  endfunction

  // Present one item from a rising edge and return at the edge that takes it.
  task automatic send_request(input row_request_t req, output int unsigned produced);
    char_code_i <= req.code;
    scale_i     <= req.scale;
    row_index_i <= req.row;
    fg_color_i  <= req.fg;
    bg_color_i  <= req.bg;
    start_i     <= 1'b1;
    do begin
      @(negedge clk_i);
    end while (busy_o !== 1'b0);
    @(posedge clk_i);
    produced = pixels_sb.note_request(req);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Hold off until every expected pixel has come and the block is idle.
  task automatic wait_drained();
    start_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pixels_sb.pending() != 0 || busy_at_neg !== 1'b0);
  endtask

  initial begin
    row_request_t      directed[$];
    row_request_t      req;
    int unsigned       produced;
    int unsigned       phase_rows;
    int unsigned       idle_pct[4];

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items: field extremes, every glyph class and each corner case.
    directed.push_back(make_request("0", 4'd1, 7'd0, 16'hFFFF, 16'h0000));
    directed.push_back(make_request("0", 4'd1, 7'd6, 16'h0000, 16'hFFFF));
    directed.push_back(make_request("0", 4'd1, 7'd7, 16'hFFFF, 16'h0000));
    directed.push_back(make_request("A", 4'd2, 7'd3, 16'h0000, 16'hFFFF));
    directed.push_back(make_request("a", 4'd3, 7'd5, 16'hF800, 16'h07E0));
    directed.push_back(make_request("z", 4'd1, 7'd2, 16'h001F, 16'hFFE0));
    directed.push_back(make_request("Z", 4'd1, 7'd4, 16'h1234, 16'hEDCB));
    directed.push_back(make_request("9", 4'd2, 7'd12, 16'hAAAA, 16'h5555));
    directed.push_back(make_request(".", 4'd1, 7'd5, 16'hFFFF, 16'h0000));
    directed.push_back(make_request(":", 4'd1, 7'd2, 16'hFFFF, 16'h0000));
    directed.push_back(make_request("-", 4'd1, 7'd3, 16'hFFFF, 16'h0000));
    directed.push_back(make_request("/", 4'd1, 7'd1, 16'hFFFF, 16'h0000));
    directed.push_back(make_request("%", 4'd1, 7'd0, 16'hFFFF, 16'h0000));
    directed.push_back(make_request("+", 4'd1, 7'd3, 16'hFFFF, 16'h0000));
    directed.push_back(make_request(8'h00, 4'd4, 7'd10, 16'hFFFF, 16'h0000));
    directed.push_back(make_request(8'hFF, 4'd1, 7'd0, 16'hFFFF, 16'h0000));
    directed.push_back(make_request(8'h7B, 4'd2, 7'd4, 16'hFFFF, 16'h0000));
    directed.push_back(make_request(8'h60, 4'd1, 7'd3, 16'hFFFF, 16'h0000));
    directed.push_back(make_request("8", 4'd0, 7'd0, 16'hFFFF, 16'hFFFF));
    directed.push_back(make_request("M", 4'd10, 7'd79, 16'hA5A5, 16'h5A5A));
    directed.push_back(make_request("W", 4'd10, 7'd64, 16'h5A5A, 16'hA5A5));
    directed.push_back(make_request("W", 4'd10, 7'd80, 16'hFFFF, 16'h0000));
    directed.push_back(make_request("1", 4'd1, 7'd8, 16'hFFFF, 16'h0000));
    directed.push_back(make_request("1", 4'd1, 7'd127, 16'hFFFF, 16'h0000));
    directed.push_back(make_request("B", 4'd11, 7'd0, 16'hFFFF, 16'hFFFF));
    directed.push_back(make_request("B", 4'd15, 7'd127, 16'hFFFF, 16'hFFFF));
    foreach (directed[i]) begin
      send_request(directed[i], produced);
    end
    wait_drained();

    // The receiver cannot hold pixels off, so only the sender idles; the
    // phases run flat out, half idle, flat out and a third idle.
    idle_pct   = '{0, 51, 0, 34};
    phase_rows = RandomItems / 4;
    foreach (idle_pct[p]) begin
      int unsigned drawn;
      drawn = 0;
      while (drawn < phase_rows) begin
        req = random_request();
        if ($urandom_range(0, 99) < idle_pct[p]) begin
          pause_sender($urandom_range(1, 4));
        end else if ($urandom_range(0, 49) == 0) begin
          wait_drained();
        end
        send_request(req, produced);
        drawn++;
      end
      wait_drained();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (pixels_sb.pending() != 0) begin
      pixels_sb.report($sformatf("%0d expected pixels never arrived",
                                 pixels_sb.pending()));
    end
    if (pixels_sb.fail_count == 0) begin
      $display("tb_scaled_glyph_row_generator OK");
    end else begin
      $display("tb_scaled_glyph_row_generator NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/sgrg_pkg.sv
hw/rtl/sgrg_glyph_rom.sv
hw/rtl/scaled_glyph_row_generator.sv
test/tb_scaled_glyph_row_generator.sv
